// ===== rtl/blrs_pkg.sv =====
package blrs_pkg;

  localparam int MAX_SRC_DIM_DEF = 256;
  localparam int MAX_OUT_DIM_DEF = 1024;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int POS_W      = 10;
  localparam int SMP_W      = 32;
  localparam int DIM_PORT_W = 11;

  // 1.0 in unsigned Q16.16
  localparam logic [SMP_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

// ===== rtl/bilinear_resample_to_pow2_square.sv =====
// Bilinear resampler of a stored luminance grid onto a square power-of-two grid.
// Each request carries a command: a write stores one Q16.16 sample at (col, row)
// of the source grid, a read returns one output pixel with its grid side and an
// out-of-range flag. One request enters per clock while the output side is not
// stalled; a read returns its result from the output register, and writes
// return nothing. The source grid sits in four parity banks (row parity by
// column parity), each with one write and one registered read port, so the four
// neighbors of a pixel come out in a single cycle; that bank fetch is the one
// memory step in the eight-stage pipe. Writes and reads reach the banks in
// request order, so a read sees every earlier write. The banks are not cleared
// at reset: every sample a read will touch must be written first. Width or
// height of zero selects a flat 1.0 image on a 2x2 grid. Configuration writes
// are taken at any time but belong to an idle block.
module bilinear_resample_to_pow2_square #(
  parameter int MAX_SRC_DIM = blrs_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_OUT_DIM = blrs_pkg::MAX_OUT_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blrs_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [blrs_pkg::POS_W-1:0]        col,
  input  logic [blrs_pkg::POS_W-1:0]        row,
  input  logic [blrs_pkg::SMP_W-1:0]        sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [blrs_pkg::SMP_W-1:0]        pixel_value,
  output logic [blrs_pkg::DIM_PORT_W-1:0]   out_dim,
  output logic                              coord_error
);

  import blrs_pkg::*;

  localparam int SRC_AW    = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int HALF_W    = (SRC_AW > 1) ? SRC_AW - 1 : 1;
  localparam int BANK_AW   = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int KMAX      = $clog2(MAX_OUT_DIM);
  localparam int DIM_W     = KMAX + 1;
  localparam int SH_W      = $clog2(KMAX + 2);
  localparam int BL_W      = $clog2(CFG_W + 1);
  localparam int FR_W      = KMAX + 1;
  localparam int WT_W      = KMAX + 2;
  localparam int NUM_W     = POS_W + 1 + CFG_W + 1;
  localparam int CW        = (DIM_W > POS_W) ? DIM_W : POS_W;
  localparam int PR_W      = SMP_W + WT_W;
  localparam int SUM_W     = PR_W + 1;

  typedef struct packed {
    logic [SRC_AW-1:0] i0;
    logic [SRC_AW-1:0] i1;
    logic [FR_W-1:0]   frac;
  } axis_t;

  // floor(num / 2^sh), neighbor index, both clamped to [0, last]; remainder as weight
  function automatic axis_t map_axis(logic signed [NUM_W-1:0] num, logic [SH_W-1:0] sh,
                                     logic [CFG_W-1:0] last);
    axis_t                   r;
    logic signed [NUM_W-1:0] lo;
    logic signed [NUM_W-1:0] hi;
    logic signed [NUM_W-1:0] lst;
    logic [NUM_W-1:0]        mask;
    lo   = num >>> sh;
    hi   = lo + NUM_W'(1);
    lst  = $signed(NUM_W'(last));
    mask = ~({NUM_W{1'b1}} << sh);
    r.frac = FR_W'(unsigned'(num) & mask);
    if (lo[NUM_W-1]) begin
      lo = '0;
    end
    if (lo > lst) begin
      lo = lst;
    end
    if (hi > lst) begin
      hi = lst;
    end
    r.i0 = SRC_AW'(lo);
    r.i1 = SRC_AW'(hi);
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= '0;
      src_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default:        src_width  <= src_width;
      endcase
    end
  end

  // ---------------------------------------------------------------- stall chain
  logic load1, load2, load3, load4, load5, load6, load7, load8;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid, s7_valid;

  assign load8    = !out_valid || out_ready;
  assign load7    = !s7_valid || load8;
  assign load6    = !s6_valid || load7;
  assign load5    = !s5_valid || load6;
  assign load4    = !s4_valid || load5;
  assign load3    = !s3_valid || load4;
  assign load2    = !s2_valid || load3;
  assign load1    = !s1_valid || load2;
  assign in_ready = load1;

  // ---------------------------------------------------------------- stage 1: decode
  logic             fb;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [CFG_W-1:0] big;
  logic [CFG_W-1:0] big_m1;
  logic [BL_W-1:0]  bl;
  logic [SH_W-1:0]  k;
  logic [DIM_W-1:0] dim;
  logic             err;
  logic             wr_ok;

  always_comb begin
    fb    = (src_width == '0) || (src_height == '0);
    w_eff = src_width;
    h_eff = src_height;
    if (32'(src_width) > 32'(MAX_SRC_DIM)) begin
      w_eff = CFG_W'(MAX_SRC_DIM);
    end
    if (32'(src_height) > 32'(MAX_SRC_DIM)) begin
      h_eff = CFG_W'(MAX_SRC_DIM);
    end
    if (fb) begin
      w_eff = CFG_W'(1);
      h_eff = CFG_W'(1);
    end
    big    = (w_eff > h_eff) ? w_eff : h_eff;
    big_m1 = big - CFG_W'(1);
    bl     = '0;
    for (int i = 0; i < CFG_W; i++) begin
      if (big_m1[i]) begin
        bl = BL_W'(i + 1);
      end
    end
    if (32'(bl) > 32'(KMAX)) begin
      k = SH_W'(KMAX);
    end else begin
      k = SH_W'(bl);
    end
    if (k == '0) begin
      k = SH_W'(1);
    end
    dim   = DIM_W'(1) << k;
    err   = (CW'(col) >= CW'(dim)) || (CW'(row) >= CW'(dim));
    wr_ok = (32'(col) < 32'(MAX_SRC_DIM)) && (32'(row) < 32'(MAX_SRC_DIM));
  end

  logic             s1_cmd;
  logic [POS_W-1:0] s1_col, s1_row;
  logic [SMP_W-1:0] s1_sample;
  logic [CFG_W-1:0] s1_w, s1_h;
  logic [SH_W-1:0]  s1_k;
  logic [DIM_W-1:0] s1_dim;
  logic             s1_fb, s1_err, s1_wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_cmd    <= command;
      s1_col    <= col;
      s1_row    <= row;
      s1_sample <= sample;
      s1_w      <= w_eff;
      s1_h      <= h_eff;
      s1_k      <= k;
      s1_dim    <= dim;
      s1_fb     <= fb;
      s1_err    <= err;
      s1_wr_ok  <= wr_ok;
    end
  end

  // ---------------------------------------------------------------- stage 2: numerators
  logic [NUM_W-1:0] prod_x, prod_y;

  assign prod_x = NUM_W'({s1_col, 1'b1}) * NUM_W'(s1_w);
  assign prod_y = NUM_W'({s1_row, 1'b1}) * NUM_W'(s1_h);

  logic                    s2_cmd;
  logic [POS_W-1:0]        s2_col, s2_row;
  logic [SMP_W-1:0]        s2_sample;
  logic signed [NUM_W-1:0] s2_num_x, s2_num_y;
  logic [CFG_W-1:0]        s2_last_x, s2_last_y;
  logic [SH_W-1:0]         s2_sh;
  logic [DIM_W-1:0]        s2_dim;
  logic                    s2_fb, s2_err, s2_wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_cmd    <= s1_cmd;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
      s2_sample <= s1_sample;
      s2_num_x  <= $signed(prod_x - NUM_W'(s1_dim));
      s2_num_y  <= $signed(prod_y - NUM_W'(s1_dim));
      s2_last_x <= s1_w - CFG_W'(1);
      s2_last_y <= s1_h - CFG_W'(1);
      s2_sh     <= s1_k + SH_W'(1);
      s2_dim    <= s1_dim;
      s2_fb     <= s1_fb;
      s2_err    <= s1_err;
      s2_wr_ok  <= s1_wr_ok;
    end
  end

  // ---------------------------------------------------------------- stage 3: neighbors
  axis_t ax, ay;

  assign ax = map_axis(s2_num_x, s2_sh, s2_last_x);
  assign ay = map_axis(s2_num_y, s2_sh, s2_last_y);

  logic              s3_cmd;
  logic [POS_W-1:0]  s3_col, s3_row;
  logic [SMP_W-1:0]  s3_sample;
  logic [SRC_AW-1:0] s3_x0, s3_x1, s3_y0, s3_y1;
  logic [FR_W-1:0]   s3_fx, s3_fy;
  logic [SH_W-1:0]   s3_sh;
  logic [DIM_W-1:0]  s3_dim;
  logic              s3_fb, s3_err, s3_wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (load3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_cmd    <= s2_cmd;
      s3_col    <= s2_col;
      s3_row    <= s2_row;
      s3_sample <= s2_sample;
      s3_x0     <= ax.i0;
      s3_x1     <= ax.i1;
      s3_y0     <= ay.i0;
      s3_y1     <= ay.i1;
      s3_fx     <= ax.frac;
      s3_fy     <= ay.frac;
      s3_sh     <= s2_sh;
      s3_dim    <= s2_dim;
      s3_fb     <= s2_fb;
      s3_err    <= s2_err;
      s3_wr_ok  <= s2_wr_ok;
    end
  end

  // ---------------------------------------------------------------- parity banks
  logic             rd_en;
  logic             wr_en;
  logic [SMP_W-1:0] bank_q [2][2];

  // writes and reads leave this stage in request order
  assign rd_en = s3_valid && (s3_cmd == CMD_READ) && load4;
  assign wr_en = s3_valid && (s3_cmd == CMD_WRITE) && s3_wr_ok && load4;

  for (genvar rp = 0; rp < 2; rp++) begin : g_row
    for (genvar cp = 0; cp < 2; cp++) begin : g_col
      logic [SRC_AW-1:0]  rsel;
      logic [SRC_AW-1:0]  csel;
      logic [BANK_AW-1:0] raddr;
      logic [BANK_AW-1:0] waddr;
      logic               we;

      assign rsel  = (s3_y0[0] == 1'(rp)) ? s3_y0 : s3_y1;
      assign csel  = (s3_x0[0] == 1'(cp)) ? s3_x0 : s3_x1;
      assign raddr = {HALF_W'(rsel >> 1), HALF_W'(csel >> 1)};
      assign waddr = {HALF_W'(s3_row >> 1), HALF_W'(s3_col >> 1)};
      assign we    = wr_en && (s3_row[0] == 1'(rp)) && (s3_col[0] == 1'(cp));

      blrs_ram #(
        .WIDTH (SMP_W),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (s3_sample),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (bank_q[rp][cp])
      );
    end
  end

  // ---------------------------------------------------------------- stage 4: bank data
  logic             s4_x0p, s4_y0p, s4_xeq, s4_yeq;
  logic [FR_W-1:0]  s4_fx, s4_fy;
  logic [SH_W-1:0]  s4_sh;
  logic [DIM_W-1:0] s4_dim;
  logic             s4_fb, s4_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (load4) begin
      s4_valid <= s3_valid && (s3_cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      s4_x0p <= s3_x0[0];
      s4_y0p <= s3_y0[0];
      s4_xeq <= (s3_x0 == s3_x1);
      s4_yeq <= (s3_y0 == s3_y1);
      s4_fx  <= s3_fx;
      s4_fy  <= s3_fy;
      s4_sh  <= s3_sh;
      s4_dim <= s3_dim;
      s4_fb  <= s3_fb;
      s4_err <= s3_err;
    end
  end

  // ---------------------------------------------------------------- stage 5: horizontal weights
  logic             xp1, yp1;
  logic [SMP_W-1:0] tl, tr, bl_q, br;
  logic [WT_W-1:0]  den4, wx0;

  always_comb begin
    // clamped edge: both neighbors come from the same bank
    xp1  = s4_xeq ? s4_x0p : !s4_x0p;
    yp1  = s4_yeq ? s4_y0p : !s4_y0p;
    tl   = bank_q[s4_y0p][s4_x0p];
    tr   = bank_q[s4_y0p][xp1];
    bl_q = bank_q[yp1][s4_x0p];
    br   = bank_q[yp1][xp1];
    den4 = WT_W'(1) << s4_sh;
    wx0  = den4 - WT_W'(s4_fx);
  end

  logic [PR_W-1:0]  s5_p00, s5_p01, s5_p10, s5_p11;
  logic [FR_W-1:0]  s5_fy;
  logic [SH_W-1:0]  s5_sh;
  logic [DIM_W-1:0] s5_dim;
  logic             s5_fb, s5_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (load5) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load5) begin
      s5_p00 <= PR_W'(tl) * PR_W'(wx0);
      s5_p01 <= PR_W'(tr) * PR_W'(s4_fx);
      s5_p10 <= PR_W'(bl_q) * PR_W'(wx0);
      s5_p11 <= PR_W'(br) * PR_W'(s4_fx);
      s5_fy  <= s4_fy;
      s5_sh  <= s4_sh;
      s5_dim <= s4_dim;
      s5_fb  <= s4_fb;
      s5_err <= s4_err;
    end
  end

  // ---------------------------------------------------------------- stage 6: row values
  logic [SUM_W-1:0] sum0, sum1;

  assign sum0 = SUM_W'(s5_p00) + SUM_W'(s5_p01);
  assign sum1 = SUM_W'(s5_p10) + SUM_W'(s5_p11);

  logic [SMP_W-1:0] s6_c0, s6_c1;
  logic [FR_W-1:0]  s6_fy;
  logic [SH_W-1:0]  s6_sh;
  logic [DIM_W-1:0] s6_dim;
  logic             s6_fb, s6_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (load6) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load6) begin
      s6_c0  <= SMP_W'(sum0 >> s5_sh);
      s6_c1  <= SMP_W'(sum1 >> s5_sh);
      s6_fy  <= s5_fy;
      s6_sh  <= s5_sh;
      s6_dim <= s5_dim;
      s6_fb  <= s5_fb;
      s6_err <= s5_err;
    end
  end

  // ---------------------------------------------------------------- stage 7: vertical weights
  logic [WT_W-1:0] den7, wy0;

  assign den7 = WT_W'(1) << s6_sh;
  assign wy0  = den7 - WT_W'(s6_fy);

  logic [PR_W-1:0]  s7_q0, s7_q1;
  logic [SH_W-1:0]  s7_sh;
  logic [DIM_W-1:0] s7_dim;
  logic             s7_fb, s7_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (load7) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load7) begin
      s7_q0  <= PR_W'(s6_c0) * PR_W'(wy0);
      s7_q1  <= PR_W'(s6_c1) * PR_W'(s6_fy);
      s7_sh  <= s6_sh;
      s7_dim <= s6_dim;
      s7_fb  <= s6_fb;
      s7_err <= s6_err;
    end
  end

  // ---------------------------------------------------------------- stage 8: output register
  logic [SUM_W-1:0] sum_v;
  logic [SMP_W-1:0] value;

  always_comb begin
    sum_v = SUM_W'(s7_q0) + SUM_W'(s7_q1);
    if (s7_err) begin
      value = '0;
    end else if (s7_fb) begin
      value = ONE_Q16;
    end else begin
      value = SMP_W'(sum_v >> s7_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load8) begin
      out_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load8) begin
      pixel_value <= value;
      out_dim     <= DIM_PORT_W'(s7_dim);
      coord_error <= s7_err;
    end
  end

endmodule

// ===== rtl/blrs_ram.sv =====
module blrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/blrs_checker.sv =====
module blrs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            command,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [blrs_pkg::SMP_W-1:0]      pixel_value,
  input logic [blrs_pkg::DIM_PORT_W-1:0] out_dim,
  input logic                            coord_error
);

  import blrs_pkg::*;

  // reads accepted whose result has not been taken yet
  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_valid && in_ready && (command == CMD_READ))
                         - 8'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(out_dim)
                                && $stable(coord_error))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coord_error |-> pixel_value == '0)
    else $error("coordinate error with nonzero pixel");

  a_dim_pow2: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_dim) && (out_dim != DIM_PORT_W'(1)))
    else $error("grid side not a power of two of at least two");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result without an open read request");

endmodule

bind bilinear_resample_to_pow2_square blrs_checker u_blrs_checker (.*);
